/* src/lsdr_pkg.sv */
// ----------------------------------------------------------------------------
// lsdr_pkg
// Shared types and constants of the shadowed character screen refresher.
// ----------------------------------------------------------------------------
`default_nettype none

package lsdr_pkg;

  // geometry defaults for the top level parameters
  localparam int MAX_ROWS_DEF = 2;
  localparam int MAX_COLS_DEF = 16;

  // byte a cell holds before it is ever written
  localparam logic [7:0] UNKNOWN_BYTE = 8'hFF;
  localparam logic [7:0] SPACE_CHAR   = 8'h20;
  localparam logic [7:0] CHAR_NONE    = 8'h00;

  // register reset values
  localparam logic [1:0] ROWS_RST = 2'd2;
  localparam logic [4:0] COLS_RST = 5'd16;

  // stream widths
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 16;

  // configuration register indexes
  localparam logic [1:0] CFG_ROWS = 2'd0;
  localparam logic [1:0] CFG_COLS = 2'd1;

  typedef enum logic [1:0] {
    FN_WRITE  = 2'd0,
    FN_FILL   = 2'd1,
    FN_CLEAR  = 2'd2,
    FN_UPDATE = 2'd3
  } func_t;

  // write strobes from the sequencer to the screen store
  typedef struct packed {
    logic w_we;   // wanted screen
    logic s_we;   // shown screen
  } lsdr_wr_t;

endpackage

`default_nettype wire

/* src/lsdr_ram.sv */
// ----------------------------------------------------------------------------
// lsdr_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module lsdr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* src/lsdr_store.sv */
// ----------------------------------------------------------------------------
// lsdr_store
// Wanted and shown screens: two RAMs plus per-cell valid bits. A cell that
// was not written since reset or the last geometry change reads as unknown.
// ----------------------------------------------------------------------------
`default_nettype none

module lsdr_store import lsdr_pkg::*; #(
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  parameter int MAX_COLS = MAX_COLS_DEF,
  localparam int CELLS = MAX_ROWS * MAX_COLS,
  localparam int AW = (CELLS > 1) ? $clog2(CELLS) : 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          clr,
  input  wire lsdr_wr_t      wr,
  input  wire logic [AW-1:0] w_addr,
  input  wire logic [7:0]    w_data,
  input  wire logic [AW-1:0] s_addr,
  input  wire logic [7:0]    s_data,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [7:0]    rd_w,
  output logic      [7:0]    rd_s
);

  logic [CELLS-1:0] wv_r;
  logic [CELLS-1:0] sv_r;
  logic             wq_r;
  logic             sq_r;
  logic             rd_in;
  logic [7:0]       w_ram;
  logic [7:0]       s_ram;

  assign rd_in = (32'(rd_addr) < 32'(CELLS));

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      wv_r <= '0;
      sv_r <= '0;
    end else begin
      if (wr.w_we) begin
        wv_r[w_addr] <= 1'b1;
      end
      if (wr.s_we) begin
        sv_r[s_addr] <= 1'b1;
      end
    end
  end

  // valid flags are registered alongside the RAM read, so they line up with its data
  always_ff @(posedge clk) begin
    wq_r <= rd_in && wv_r[rd_addr];
    sq_r <= rd_in && sv_r[rd_addr];
  end

  lsdr_ram #(.WIDTH(8), .DEPTH(CELLS)) u_wanted (
    .clk  (clk),
    .we   (wr.w_we),
    .waddr(w_addr),
    .wdata(w_data),
    .raddr(rd_addr),
    .rdata(w_ram)
  );

  lsdr_ram #(.WIDTH(8), .DEPTH(CELLS)) u_shown (
    .clk  (clk),
    .we   (wr.s_we),
    .waddr(s_addr),
    .wdata(s_data),
    .raddr(rd_addr),
    .rdata(s_ram)
  );

  assign rd_w = wq_r ? w_ram : UNKNOWN_BYTE;
  assign rd_s = sq_r ? s_ram : UNKNOWN_BYTE;

endmodule

`default_nettype wire

/* src/lsdr_seq.sv */
// ----------------------------------------------------------------------------
// lsdr_seq
// Request sequencer: fills the wanted screen one cell a cycle; on update walks
// both screens one cell a cycle unless stalled, through a single compare unit.
// ----------------------------------------------------------------------------
`default_nettype none

module lsdr_seq import lsdr_pkg::*; #(
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  parameter int MAX_COLS = MAX_COLS_DEF,
  localparam int CELLS = MAX_ROWS * MAX_COLS,
  localparam int AW  = (CELLS > 1) ? $clog2(CELLS) : 1,
  localparam int IW  = $clog2(CELLS + 2),
  localparam int ERW = $clog2(MAX_ROWS + 1),
  localparam int ECW = $clog2(MAX_COLS + 1)
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic [ERW-1:0] eff_rows,
  input  wire logic [ECW-1:0] eff_cols,
  input  wire logic [IW-1:0]  n_cells,
  input  wire logic           in_vld,
  output logic                in_rdy,
  input  wire func_t          in_func,
  input  wire logic           in_row,
  input  wire logic [3:0]     in_col,
  input  wire logic [7:0]     in_char,
  input  wire logic [4:0]     in_count,
  output logic                out_vld,
  input  wire logic           out_rdy,
  output logic                out_row,
  output logic      [3:0]     out_col,
  output logic      [7:0]     out_char,
  output logic                out_start,
  output logic                out_last,
  output lsdr_wr_t            wr,
  output logic      [AW-1:0]  w_addr,
  output logic      [7:0]     w_data,
  output logic      [AW-1:0]  s_addr,
  output logic      [7:0]     s_data,
  output logic      [AW-1:0]  rd_addr,
  input  wire logic [7:0]     rd_w,
  input  wire logic [7:0]     rd_s
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILL,
    S_LOAD,
    S_STEP,
    S_FLUSH
  } state_t;

  state_t         state_r,  state_nxt;
  logic [IW-1:0]  ptr_r,    ptr_nxt;
  logic [IW-1:0]  rem_r,    rem_nxt;
  logic [7:0]     fch_r,    fch_nxt;
  logic [ERW-1:0] row_r,    row_nxt;
  logic [ECW-1:0] col_r,    col_nxt;
  logic           dcur_r,   dcur_nxt;
  logic [7:0]     wcur_r,   wcur_nxt;
  logic           run_r,    run_nxt;
  logic           pv_r,     pv_nxt;
  logic           prow_r,   prow_nxt;
  logic [3:0]     pcol_r,   pcol_nxt;
  logic [7:0]     pchar_r,  pchar_nxt;
  logic           pstart_r, pstart_nxt;
  logic           ov_r,     ov_nxt;
  logic           orow_r,   orow_nxt;
  logic [3:0]     ocol_r,   ocol_nxt;
  logic [7:0]     ochar_r,  ochar_nxt;
  logic           ostart_r, ostart_nxt;
  logic           olast_r,  olast_nxt;

  logic [31:0]    avail;
  logic [31:0]    fill_len;
  logic [31:0]    wr_len;
  logic [31:0]    base;
  logic           on_screen;
  logic           cell_diff;
  logic           nxt_exists;
  logic           d_next;
  logic           emit;
  logic           out_free;
  logic           advance;
  logic [IW-1:0]  rd_full;

  // decode of a write or fill request
  assign on_screen = (32'(in_row) < 32'(eff_rows)) && (32'(in_col) < 32'(eff_cols));
  assign avail     = 32'(eff_cols) - 32'(in_col);
  assign fill_len  = (32'(in_count) > avail) ? avail : 32'(in_count);
  assign wr_len    = (in_func == FN_WRITE) ? ((in_count != 5'd0) ? 32'd1 : 32'd0)
                                           : fill_len;
  assign base      = in_row ? 32'(eff_cols) : 32'd0;

  // compare unit: a wanted zero is transparent and never differs
  assign cell_diff  = (rd_w != rd_s) && (rd_w != CHAR_NONE);
  assign nxt_exists = ({1'b0, ptr_r} + (IW+1)'(1)) < {1'b0, n_cells};
  assign d_next     = nxt_exists && cell_diff;
  // inside a run a matching cell is bridged when the next one differs
  assign emit       = run_r ? (dcur_r || d_next) : dcur_r;
  assign out_free   = !ov_r || out_rdy;
  assign advance    = !(emit && pv_r && !out_free);

  assign in_rdy = (state_r == S_IDLE);

  always_comb begin
    case (state_r)
      S_LOAD:  rd_full = ptr_r + IW'(1);
      S_STEP:  rd_full = advance ? (ptr_r + IW'(2)) : (ptr_r + IW'(1));
      default: rd_full = '0;
    endcase
  end
  assign rd_addr = rd_full[AW-1:0];

  assign wr.w_we = (state_r == S_FILL);
  assign w_addr  = ptr_r[AW-1:0];
  assign w_data  = fch_r;
  assign wr.s_we = (state_r == S_STEP) && advance && (emit || (wcur_r == CHAR_NONE));
  assign s_addr  = ptr_r[AW-1:0];
  assign s_data  = wcur_r;

  always_comb begin
    state_nxt  = state_r;
    ptr_nxt    = ptr_r;
    rem_nxt    = rem_r;
    fch_nxt    = fch_r;
    row_nxt    = row_r;
    col_nxt    = col_r;
    dcur_nxt   = dcur_r;
    wcur_nxt   = wcur_r;
    run_nxt    = run_r;
    pv_nxt     = pv_r;
    prow_nxt   = prow_r;
    pcol_nxt   = pcol_r;
    pchar_nxt  = pchar_r;
    pstart_nxt = pstart_r;
    ov_nxt     = ov_r && !out_rdy;
    orow_nxt   = orow_r;
    ocol_nxt   = ocol_r;
    ochar_nxt  = ochar_r;
    ostart_nxt = ostart_r;
    olast_nxt  = olast_r;

    case (state_r)
      S_IDLE: begin
        if (in_vld) begin
          case (in_func)
            FN_WRITE, FN_FILL: begin
              if (on_screen && (wr_len != 32'd0)) begin
                ptr_nxt   = IW'(base + 32'(in_col));
                rem_nxt   = IW'(wr_len);
                fch_nxt   = in_char;
                state_nxt = S_FILL;
              end
            end
            FN_CLEAR: begin
              if (n_cells != '0) begin
                ptr_nxt   = '0;
                rem_nxt   = n_cells;
                fch_nxt   = SPACE_CHAR;
                state_nxt = S_FILL;
              end
            end
            FN_UPDATE: begin
              if (n_cells != '0) begin
                ptr_nxt   = '0;
                row_nxt   = '0;
                col_nxt   = '0;
                run_nxt   = 1'b0;
                state_nxt = S_LOAD;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end

      S_FILL: begin
        ptr_nxt = ptr_r + IW'(1);
        rem_nxt = rem_r - IW'(1);
        if (rem_r == IW'(1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_LOAD: begin
        dcur_nxt  = cell_diff;
        wcur_nxt  = rd_w;
        state_nxt = S_STEP;
      end

      S_STEP: begin
        if (advance) begin
          if (emit) begin
            if (pv_r) begin
              ov_nxt     = 1'b1;
              orow_nxt   = prow_r;
              ocol_nxt   = pcol_r;
              ochar_nxt  = pchar_r;
              ostart_nxt = pstart_r;
              olast_nxt  = 1'b0;
            end
            pv_nxt     = 1'b1;
            prow_nxt   = 1'(row_r);
            pcol_nxt   = 4'(col_r);
            pchar_nxt  = wcur_r;
            pstart_nxt = !run_r;
          end
          run_nxt  = emit;
          dcur_nxt = d_next;
          wcur_nxt = rd_w;
          ptr_nxt  = ptr_r + IW'(1);
          if (col_r == (eff_cols - ECW'(1))) begin
            col_nxt = '0;
            row_nxt = row_r + ERW'(1);
          end else begin
            col_nxt = col_r + ECW'(1);
          end
          if (!nxt_exists) begin
            state_nxt = S_FLUSH;
          end
        end
      end

      S_FLUSH: begin
        if (!pv_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          ov_nxt     = 1'b1;
          orow_nxt   = prow_r;
          ocol_nxt   = pcol_r;
          ochar_nxt  = pchar_r;
          ostart_nxt = pstart_r;
          olast_nxt  = 1'b1;
          pv_nxt     = 1'b0;
          state_nxt  = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      run_r   <= 1'b0;
      pv_r    <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      run_r   <= run_nxt;
      pv_r    <= pv_nxt;
      ov_r    <= ov_nxt;
    end
    ptr_r    <= ptr_nxt;
    rem_r    <= rem_nxt;
    fch_r    <= fch_nxt;
    row_r    <= row_nxt;
    col_r    <= col_nxt;
    dcur_r   <= dcur_nxt;
    wcur_r   <= wcur_nxt;
    prow_r   <= prow_nxt;
    pcol_r   <= pcol_nxt;
    pchar_r  <= pchar_nxt;
    pstart_r <= pstart_nxt;
    orow_r   <= orow_nxt;
    ocol_r   <= ocol_nxt;
    ochar_r  <= ochar_nxt;
    ostart_r <= ostart_nxt;
    olast_r  <= olast_nxt;
  end

  assign out_vld   = ov_r;
  assign out_row   = orow_r;
  assign out_col   = ocol_r;
  assign out_char  = ochar_r;
  assign out_start = ostart_r;
  assign out_last  = olast_r;

endmodule

`default_nettype wire

/* src/lcd_shadow_diff_runs.sv */
// ----------------------------------------------------------------------------
// lcd_shadow_diff_runs
// Wanted/shown character screen pair with differential run output.
// ----------------------------------------------------------------------------
// Takes one request at a time; in_tready is low while a request is worked on.
// A write or fill writes its cells one after another, a clear every cell in
// use, both through the single write port of the wanted screen RAM. An
// update walks the cells in use: the compare unit looks at one cell per cycle
// through the shared read address of both screen RAMs, and the walk pauses
// whenever out_tready holds back a character. There is no clearing pass
// after reset or a geometry write: per-cell valid bits mark both screens
// unknown at once.
`default_nettype none

module lcd_shadow_diff_runs import lsdr_pkg::*; #(
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  parameter int MAX_COLS = MAX_COLS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // row[0], col[4:1], char_code[12:5], count[17:13], zero[23:18]
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // func[1:0]
  input  wire logic [1:0]             in_tuser,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // out_row[0], out_col[4:1], out_char[12:5], zero[15:13]
  output logic      [OUT_TDATA_W-1:0] out_tdata,
  // run_start[0]
  output logic      [0:0]             out_tuser,
  output logic                        out_tlast,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [1:0]             cfg_index,
  input  wire logic [7:0]             cfg_data
);

  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int AW  = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int IW  = $clog2(CELLS + 2);
  localparam int ERW = $clog2(MAX_ROWS + 1);
  localparam int ECW = $clog2(MAX_COLS + 1);
  localparam int PW  = ERW + ECW;

  logic [1:0]     rows_r;
  logic [4:0]     cols_r;
  logic           clr;
  logic [ERW-1:0] eff_rows;
  logic [ECW-1:0] eff_cols;
  logic [PW-1:0]  prod;
  logic [IW-1:0]  n_cells;

  lsdr_wr_t       wr;
  logic [AW-1:0]  w_addr;
  logic [7:0]     w_data;
  logic [AW-1:0]  s_addr;
  logic [7:0]     s_data;
  logic [AW-1:0]  rd_addr;
  logic [7:0]     rd_w;
  logic [7:0]     rd_s;

  logic           o_row;
  logic [3:0]     o_col;
  logic [7:0]     o_char;
  logic           o_start;

  // configuration; a geometry change forgets both screens
  assign cfg_ready = 1'b1;
  assign clr = cfg_valid && ((cfg_index == CFG_ROWS) || (cfg_index == CFG_COLS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= ROWS_RST;
      cols_r <= COLS_RST;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_ROWS) begin
        rows_r <= cfg_data[1:0];
      end else if (cfg_index == CFG_COLS) begin
        cols_r <= cfg_data[4:0];
      end
    end
  end

  always_comb begin
    if (32'(rows_r) > 32'(MAX_ROWS)) begin
      eff_rows = ERW'(MAX_ROWS);
    end else begin
      eff_rows = ERW'(rows_r);
    end
    if (32'(cols_r) > 32'(MAX_COLS)) begin
      eff_cols = ECW'(MAX_COLS);
    end else begin
      eff_cols = ECW'(cols_r);
    end
  end

  assign prod    = PW'(eff_rows) * PW'(eff_cols);
  assign n_cells = IW'(prod);

  lsdr_seq #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .eff_rows (eff_rows),
    .eff_cols (eff_cols),
    .n_cells  (n_cells),
    .in_vld   (in_tvalid),
    .in_rdy   (in_tready),
    .in_func  (func_t'(in_tuser)),
    .in_row   (in_tdata[0]),
    .in_col   (in_tdata[4:1]),
    .in_char  (in_tdata[12:5]),
    .in_count (in_tdata[17:13]),
    .out_vld  (out_tvalid),
    .out_rdy  (out_tready),
    .out_row  (o_row),
    .out_col  (o_col),
    .out_char (o_char),
    .out_start(o_start),
    .out_last (out_tlast),
    .wr       (wr),
    .w_addr   (w_addr),
    .w_data   (w_data),
    .s_addr   (s_addr),
    .s_data   (s_data),
    .rd_addr  (rd_addr),
    .rd_w     (rd_w),
    .rd_s     (rd_s)
  );

  lsdr_store #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .clr    (clr),
    .wr     (wr),
    .w_addr (w_addr),
    .w_data (w_data),
    .s_addr (s_addr),
    .s_data (s_data),
    .rd_addr(rd_addr),
    .rd_w   (rd_w),
    .rd_s   (rd_s)
  );

  assign out_tdata = {3'b000, o_char, o_col, o_row};
  assign out_tuser = o_start;

endmodule

`default_nettype wire

/* src/lsdr_chk.sv */
// ----------------------------------------------------------------------------
// lsdr_chk
// Port-level checks of the screen refresher, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lsdr_chk import lsdr_pkg::*; (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_tready,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata,
  input wire logic [0:0]             out_tuser,
  input wire logic                   out_tlast
);

  // set while the next character is the first of an update
  logic first_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= 1'b1;
    end else if (out_tvalid && out_tready) begin
      first_r <= out_tlast;
    end
  end

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("outputs not quiet after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled character changed");

  a_first_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && first_r |-> out_tuser[0])
    else $error("update does not open with a run start");

endmodule

bind lcd_shadow_diff_runs lsdr_chk u_chk (.*);

`default_nettype wire
